/* rtl/ipv4c_pkg.sv */
// shared types, codes and constants of the ipv4 / cidr text validator
package ipv4c_pkg;

   typedef enum logic [1:0] {
      PH_ADDR   = 2'd0,
      PH_LEAD   = 2'd1,
      PH_SIGN   = 2'd2,
      PH_DIGITS = 2'd3
   } phase_type;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_DOT   = 8'd46;
   localparam logic [7:0] CH_SLASH = 8'd47;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;

   localparam logic [11:0] OCTET_MAX  = 12'd255;
   localparam logic [8:0]  PREFIX_SAT = 9'd33;
   localparam logic [5:0]  PREFIX_MAX = 6'd32;
   localparam logic [1:0]  MAX_DIGITS = 2'd3;
   localparam logic [1:0]  MAX_DOTS   = 2'd3;

   typedef struct packed {
      phase_type   phase;
      logic        failed;
      logic        seen_char;
      logic [7:0]  octet_value;
      logic [1:0]  digit_count;
      logic [1:0]  octet_count;
      logic [5:0]  prefix_value;
      logic        prefix_negative;
   } parser_state_type;

   localparam parser_state_type PARSER_RESET = '{
      phase:           PH_ADDR,
      failed:          1'b0,
      seen_char:       1'b0,
      octet_value:     8'd0,
      digit_count:     2'd0,
      octet_count:     2'd0,
      prefix_value:    6'd0,
      prefix_negative: 1'b0
   };

endpackage

/* rtl/ipv4_or_cidr_text_validator.sv */
// top level of the ipv4 / cidr text validator: input register, parser state, result register
// an end word's verdict passes the input register, then the result register, before it is on rsp_;
//   character words give no result
// throughput: one word per cycle while no end word is held by a stalled result
// a stalled result holds only end words; character words keep flowing while no end word waits
// reset: synchronous, active high; clears the pipeline valids and the parser state
// parser state returns to its reset value after every end word
module ipv4_or_cidr_text_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   input  logic [7:0] req_ch,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_valid_res
);
   import ipv4c_pkg::*;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_op_ff;
   logic [7:0] s1_ch_ff;

   // parser state
   parser_state_type state_ff, state_in;
   parser_state_type step_state;
   logic             step_verdict;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_valid_res_ff, rsp_valid_res_in;

   logic s1_advance;
   logic s1_is_end;
   logic out_free;

   ipv4c_parser_step u_step (
      .cur_state (state_ff),
      .ch        (s1_ch_ff),
      .nxt_state (step_state),
      .verdict   (step_verdict)
   );

   // result slot frees when empty or being taken this cycle
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_is_end  = (s1_op_ff == OP_END);
   // characters never need the result slot
   assign s1_advance = s1_valid_ff && (!s1_is_end || out_free);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_valid_in      = s1_valid_ff;
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_valid_res_in = rsp_valid_res_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_advance) begin
         s1_valid_in = 1'b0;
         if (s1_is_end) begin
            state_in         = PARSER_RESET;
            rsp_valid_in     = 1'b1;
            rsp_valid_res_in = step_verdict;
         end else begin
            state_in = step_state;
         end
      end

      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= PARSER_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_op_ff <= req_op;
         s1_ch_ff <= req_ch;
      end
      rsp_valid_res_ff <= rsp_valid_res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_valid_res_ff;

   // an end word always leaves the parser in its reset state
   a_end_clears_state: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_is_end) |=> (state_ff == PARSER_RESET))
      else $error("parser state not cleared after end word");

   // a result appears only from an end word leaving the input register
   a_result_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_advance && s1_is_end))
      else $error("result raised without an end word");

   // input stalls only behind a held end word and a blocked result slot
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s1_is_end && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without cause");

endmodule

/* rtl/ipv4c_parser_step.sv */
// next parser state for one character, and the verdict of the current state
module ipv4c_parser_step (
   input  ipv4c_pkg::parser_state_type cur_state,
   input  logic [7:0]                  ch,
   output ipv4c_pkg::parser_state_type nxt_state,
   output logic                        verdict
);
   import ipv4c_pkg::*;

   logic        is_digit;
   logic        is_space;
   logic [3:0]  digit_val;
   logic [11:0] octet_sum;
   logic [8:0]  prefix_sum;

   assign digit_val  = 4'(ch - CH_ZERO);
   assign octet_sum  = 12'(cur_state.octet_value) * 12'd10 + 12'(digit_val);
   assign prefix_sum = 9'(cur_state.prefix_value) * 9'd10 + 9'(digit_val);

   always_comb begin
      is_digit = ch inside {[CH_ZERO:CH_NINE]};
      is_space = (ch == CH_SPACE) || (ch inside {[CH_TAB:CH_CR]});
      nxt_state = cur_state;
      nxt_state.seen_char = 1'b1;
      if (!cur_state.failed) begin
         case (cur_state.phase)
            PH_ADDR: begin
               if (is_digit) begin
                  if (cur_state.digit_count >= MAX_DIGITS || octet_sum > OCTET_MAX) begin
                     nxt_state.failed = 1'b1;
                  end else begin
                     nxt_state.octet_value = octet_sum[7:0];
                     nxt_state.digit_count = cur_state.digit_count + 2'd1;
                  end
               end else if (ch == CH_DOT) begin
                  if (cur_state.digit_count == 2'd0 || cur_state.octet_count >= MAX_DOTS) begin
                     nxt_state.failed = 1'b1;
                  end else begin
                     nxt_state.octet_count = cur_state.octet_count + 2'd1;
                     nxt_state.octet_value = 8'd0;
                     nxt_state.digit_count = 2'd0;
                  end
               end else if (ch == CH_SLASH) begin
                  if (cur_state.digit_count == 2'd0 || cur_state.octet_count != MAX_DOTS) begin
                     nxt_state.failed = 1'b1;
                  end else begin
                     nxt_state.phase = PH_LEAD;
                  end
               end else begin
                  nxt_state.failed = 1'b1;
               end
            end
            default: begin
               if (is_digit) begin
                  // accumulator saturates one past the largest legal length
                  nxt_state.prefix_value = (prefix_sum > PREFIX_SAT) ? PREFIX_SAT[5:0]
                                                                     : prefix_sum[5:0];
                  nxt_state.phase = PH_DIGITS;
               end else if (cur_state.phase == PH_LEAD && is_space) begin
                  nxt_state.phase = PH_LEAD;
               end else if (cur_state.phase == PH_LEAD &&
                            (ch == CH_PLUS || ch == CH_MINUS)) begin
                  nxt_state.prefix_negative = (ch == CH_MINUS);
                  nxt_state.phase = PH_SIGN;
               end else begin
                  nxt_state.failed = 1'b1;
               end
            end
         endcase
      end
   end

   always_comb begin
      if (!cur_state.seen_char) begin
         verdict = 1'b1;
      end else if (cur_state.failed) begin
         verdict = 1'b0;
      end else begin
         case (cur_state.phase)
            PH_ADDR: begin
               verdict = (cur_state.digit_count != 2'd0) && (cur_state.octet_count == MAX_DOTS);
            end
            PH_DIGITS: begin
               verdict = (cur_state.prefix_value <= PREFIX_MAX) &&
                         (!cur_state.prefix_negative || cur_state.prefix_value == 6'd0);
            end
            default: begin
               verdict = 1'b0;
            end
         endcase
      end
   end

endmodule
